[sv/chmf_pkg.sv]
// Shared constants, types and command/status structs of the contraharmonic mean filter.
package chmf_pkg;

  localparam int unsigned MaxWidth = 2048;
  localparam int unsigned Span     = 3;
  localparam int unsigned Half     = (Span - 1) / 2;
  localparam int unsigned NumPix   = Span * Span;
  localparam int unsigned QMax     = 4;

  localparam int unsigned PixW     = 8;
  localparam int unsigned WidthW   = 12;
  localparam int unsigned HeightW  = 13;
  localparam int unsigned QW       = 3;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned EffW     = ColW + 1;
  localparam int unsigned RowW     = 13;
  localparam int unsigned OrowW    = RowW + 2;
  localparam int unsigned PixIdxW  = $clog2(NumPix);
  localparam int unsigned DivCntW  = $clog2(PixW);
  localparam int unsigned PowW     = PixW * (QMax + 1);
  localparam int unsigned NumW     = PowW + $clog2(NumPix);
  localparam int unsigned DenW     = PixW * QMax + $clog2(NumPix);
  localparam int unsigned LineW    = 2 * PixW;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;

  localparam logic [WidthW-1:0]  WidthReset  = WidthW'(640);
  localparam logic [HeightW-1:0] HeightReset = HeightW'(480);
  localparam logic [QW-1:0]      QReset      = QW'(1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_Q      = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic load;
    logic mul;
    logic acc;
    logic div;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic interior;
    logic exp_done;
    logic pix_last;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

[sv/chmf_if.sv]
// Handshake channel interfaces for pixel input, filtered output and register writes.
interface chmf_in_if import chmf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_in;
  logic            drain;
  modport source (output valid, pixel_in, drain, input ready);
  modport sink   (input valid, pixel_in, drain, output ready);
endinterface

interface chmf_out_if import chmf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_out;
  logic            frame_end;
  modport source (output valid, pixel_out, frame_end, input ready);
  modport sink   (input valid, pixel_out, frame_end, output ready);
endinterface

interface chmf_cfg_if import chmf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/contraharmonic_mean_window_filter.sv]
// Top level of the 3x3 contraharmonic mean image filter.
//
// Pixels of an 8-bit grey frame arrive on in_ch in raster order, one request
// per pixel; a request with drain set is a filler whose pixel is taken as 0.
// Filtered pixels leave on out_ch, each with frame_end set on the last pixel
// of the output frame. The output lags the input by one row plus one pixel,
// so one row plus one pixel of drain requests push out the frame's tail.
// Registers (width, height, order Q) are written on cfg_ch, which is always
// ready; any register write restarts the raster position at the frame start.
// Requests are processed one at a time. The time for an interior pixel is set
// by one shared 40x8 multiplier that raises each of the nine window pixels
// to the powers Q and Q+1 in turn, followed by an 8-step restoring divider.
// The result sits in an output register, so a new request is taken while an
// earlier result waits; a stalled receiver only holds up the block once a
// second result is ready. Reset clears counters, window and control; the
// line store needs no clearing pass because stale entries only reach the
// window rows of border pixels, whose output is the centre pixel.
module contraharmonic_mean_window_filter import chmf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  chmf_in_if.sink     in_ch,
  chmf_out_if.source  out_ch,
  chmf_cfg_if.sink    cfg_ch
);

  cmd_t    cmd;
  status_t status;

  // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
  assign cfg_ch.ready = 1'b1;

  chmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  chmf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .pixel_in_i  (in_ch.pixel_in),
    .drain_i     (in_ch.drain),
    .cfg_valid_i (cfg_ch.valid),
    .cfg_index_i (cfg_ch.index),
    .cfg_data_i  (cfg_ch.data),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .pixel_out_o (out_ch.pixel_out),
    .frame_end_o (out_ch.frame_end)
  );

endmodule

[sv/chmf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module chmf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/chmf_ctrl.sv]
// Controller state machine that sequences load, power accumulation, division and output.
module chmf_ctrl import chmf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (!status_i.emit) state_d = ST_IDLE;
        else if (!status_i.interior) state_d = ST_DONE;
        else state_d = ST_MUL;
      end
      ST_MUL: begin
        if (status_i.exp_done) state_d = ST_ACC;
      end
      ST_ACC: begin
        state_d = status_i.pix_last ? ST_DIV : ST_MUL;
      end
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.accept  = in_valid_i;
      end
      ST_LOAD: cmd_o.load = 1'b1;
      ST_MUL:  cmd_o.mul  = 1'b1;
      ST_ACC:  cmd_o.acc  = 1'b1;
      ST_DIV:  cmd_o.div  = 1'b1;
      ST_DONE: cmd_o.out_load = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_LOAD))
    else $error("accepted request did not enter load");

  a_out_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.emit)
    else $error("result loaded for a request that emits nothing");

  a_compute_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_ACC || state_q == ST_DIV) |-> status_i.interior)
    else $error("arithmetic running for a border pixel");

endmodule

[sv/chmf_datapath.sv]
// Datapath: registers, raster counters, line store, window, power sums, divider, output.
module chmf_datapath import chmf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic [PixW-1:0]     pixel_in_i,
  input  logic                drain_i,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PixW-1:0]     pixel_out_o,
  output logic                frame_end_o
);

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [QW-1:0]      q_q;
  logic [ColW-1:0]    col_q, col_wr_q;
  logic [RowW-1:0]    row_q;

  logic [EffW-1:0]    w_eff;
  logic [HeightW-1:0] h_eff;
  logic [QW-1:0]      q_eff;
  logic [ColW-1:0]    ocol;
  logic [OrowW-1:0]   orow;
  logic [RowW:0]      orow_v;
  logic               orow_neg, emit, over, last, interior, cfg_hit;

  logic [PixW-1:0]    pix_q;
  logic               emit_q, last_q, interior_q;
  logic [LineW-1:0]   line_rd;
  logic [PixW-1:0]    win_q [NumPix];
  logic [PixIdxW-1:0] pi_q;
  logic [QW-1:0]      ej_q;
  logic [DivCntW-1:0] db_q;
  logic [PowW-1:0]    pw_q;
  logic [NumW-1:0]    num_q, den_sh;
  logic [DenW-1:0]    den_q;
  logic [PixW-1:0]    quo_q, sel;
  logic               out_valid_q, frame_end_q;
  logic [PixW-1:0]    pix_out_q;

  always_comb begin
    if (width_q == '0) w_eff = EffW'(1);
    else if (32'(width_q) > MaxWidth) w_eff = EffW'(MaxWidth);
    else w_eff = EffW'(width_q);
    h_eff = (height_q == '0) ? HeightW'(1) : height_q;
    q_eff = (32'(q_q) > QMax) ? QW'(QMax) : q_q;
  end

  // Output lags the input by one row and one pixel.
  always_comb begin
    ocol     = (col_q == '0) ? ColW'(w_eff - EffW'(1)) : col_q - ColW'(1);
    orow     = {2'b00, row_q} - ((col_q == '0) ? OrowW'(2) : OrowW'(1));
    orow_neg = orow[OrowW-1];
    orow_v   = orow[RowW:0];
    emit     = !orow_neg && (orow_v < {1'b0, h_eff});
    over     = !orow_neg && !(orow_v < {1'b0, h_eff});
    last     = emit && (orow_v == ({1'b0, h_eff} - (RowW+1)'(1)))
               && ({1'b0, ocol} == w_eff - EffW'(1));
    interior = (orow_v != '0) && ((orow_v + (RowW+1)'(1)) < {1'b0, h_eff})
               && (ocol != '0) && (({1'b0, ocol} + EffW'(1)) < w_eff);
  end

  assign cfg_hit = cfg_valid_i && (cfg_index_i == CFG_WIDTH || cfg_index_i == CFG_HEIGHT
                                   || cfg_index_i == CFG_Q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      q_q      <= QReset;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_WIDTH:  width_q  <= cfg_data_i[WidthW-1:0];
          CFG_HEIGHT: height_q <= cfg_data_i[HeightW-1:0];
          CFG_Q:      q_q      <= cfg_data_i[QW-1:0];
          default:    ;
        endcase
      end
      if (cfg_hit || (cmd_i.accept && (last || over))) begin
        col_q <= '0;
        row_q <= '0;
      end else if (cmd_i.accept) begin
        if (({1'b0, col_q} + EffW'(1)) == w_eff) begin
          col_q <= '0;
          row_q <= row_q + RowW'(1);
        end else begin
          col_q <= col_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q     <= 1'b0;
      last_q     <= 1'b0;
      interior_q <= 1'b0;
    end else if (cmd_i.accept) begin
      emit_q     <= emit;
      last_q     <= last;
      interior_q <= interior;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q    <= drain_i ? '0 : pixel_in_i;
      col_wr_q <= col_q;
    end
  end

  // Each entry holds the two previous rows of one column: older in the upper byte.
  chmf_ram #(
    .Width (LineW),
    .Depth (MaxWidth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (col_wr_q),
    .wdata_i ({line_rd[PixW-1:0], pix_q}),
    .re_i    (cmd_i.accept),
    .raddr_i (col_q),
    .rdata_o (line_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPix; i++) win_q[i] <= '0;
    end else if (cmd_i.load) begin
      for (int r = 0; r < Span; r++) begin
        for (int c = 0; c < Span - 1; c++) begin
          win_q[r*Span + c] <= win_q[r*Span + c + 1];
        end
      end
      win_q[Span - 1]          <= line_rd[LineW-1:PixW];
      win_q[2*Span - 1]        <= line_rd[PixW-1:0];
      win_q[Span*Span - 1]     <= pix_q;
    end
  end

  assign sel    = win_q[pi_q];
  assign den_sh = NumW'(den_q) << db_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q <= '0;
      den_q <= '0;
      pw_q  <= PowW'(1);
      pi_q  <= '0;
      ej_q  <= '0;
      db_q  <= DivCntW'(PixW - 1);
      quo_q <= '0;
    end else if (cmd_i.mul) begin
      if (ej_q == q_eff) den_q <= den_q + DenW'(pw_q);
      pw_q <= PowW'(pw_q * PowW'(sel));
      ej_q <= ej_q + QW'(1);
    end else if (cmd_i.acc) begin
      num_q <= num_q + NumW'(pw_q);
      pi_q  <= pi_q + PixIdxW'(1);
      ej_q  <= '0;
      pw_q  <= PowW'(1);
    end else if (cmd_i.div) begin
      // Restoring division, one quotient bit per cycle, most significant first.
      if (num_q >= den_sh) begin
        num_q       <= num_q - den_sh;
        quo_q[db_q] <= 1'b1;
      end
      db_q <= db_q - DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      frame_end_q <= last_q;
      if (!interior_q) pix_out_q <= win_q[Half*Span + Half];
      else if (den_q == '0) pix_out_q <= '0;
      else pix_out_q <= quo_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pix_out_q;
  assign frame_end_o = frame_end_q;

  always_comb begin
    status_o          = '0;
    status_o.emit     = emit_q;
    status_o.interior = interior_q;
    status_o.exp_done = (ej_q == q_eff);
    status_o.pix_last = (pi_q == PixIdxW'(NumPix - 1));
    status_o.div_last = (db_q == '0);
    status_o.out_free = !out_valid_q || out_ready_i;
  end

endmodule
